// ===== rtl/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared codes, constants and handshake types for the integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int RESULT_BITS = 32;
    localparam int DIGIT_W     = 8;

    localparam logic [2:0] OP_MUL = 3'd0;
    localparam logic [2:0] OP_DIV = 3'd1;
    localparam logic [2:0] OP_ADD = 3'd2;
    localparam logic [2:0] OP_SUB = 3'd3;
    localparam logic [2:0] OP_REM = 3'd4;
    localparam logic [2:0] OP_POW = 3'd5;
    localparam logic [2:0] OP_NCR = 3'd6;
    localparam logic [2:0] OP_NPR = 3'd7;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIV0   = 2'd1;
    localparam logic [1:0] ST_DOMAIN = 2'd2;

    typedef struct packed {
        logic go;
        logic div;
    } t_mdu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_rsp;

endpackage

// ===== rtl/integer_alu_with_ncr_npr_top.sv =====
// ----------------------------------------------------------------------------
// integer_alu_with_ncr_npr_top
// Integer ALU: mul, div, add, sub, rem, power, nCr, nPr over one shared
// iterative multiply/divide unit under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  command   in   start & !busy    i_operand_a, i_operation, i_operand_b
//  result    out  o_valid (1 cyc)  o_result, o_status
//
//  Work per item (IW = internal width, 32 by default):
//    add/sub none on the shared unit; mul one multiply; div/rem one divide;
//    pow a multiply or square per exponent step; nCr a multiply and a
//    divide per k; nPr a multiply per k, all on the one shared unit.
//  busy is high from acceptance until the result strobe; reset clears it.
//  The result strobe cannot be held off.
// ----------------------------------------------------------------------------
module integer_alu_with_ncr_npr_top #(
    parameter int DATA_WIDTH = 32,
    parameter int MAX_FACT_N = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [DATA_WIDTH-1:0]  i_operand_a,
    input  logic [2:0]             i_operation,
    input  logic [DATA_WIDTH-1:0]  i_operand_b,
    output logic                   o_valid,
    output logic [(DATA_WIDTH < ialu_pkg::RESULT_BITS ? DATA_WIDTH
                   : ialu_pkg::RESULT_BITS)-1:0] o_result,
    output logic [1:0]             o_status
);

    localparam int RES_W = DATA_WIDTH < ialu_pkg::RESULT_BITS ? DATA_WIDTH
                           : ialu_pkg::RESULT_BITS;
    localparam int CW    = MAX_FACT_N + $clog2(MAX_FACT_N + 1);
    localparam int IW    = DATA_WIDTH > CW ? DATA_WIDTH : CW;
    localparam int KW    = $clog2(MAX_FACT_N + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_WAIT     = 4'd2;
    localparam logic [3:0] S_PW_CHK   = 4'd3;
    localparam logic [3:0] S_PW_MUL   = 4'd4;
    localparam logic [3:0] S_PW_SQ    = 4'd5;
    localparam logic [3:0] S_CB_CHK   = 4'd6;
    localparam logic [3:0] S_CB_MUL   = 4'd7;
    localparam logic [3:0] S_CB_DIVGO = 4'd8;
    localparam logic [3:0] S_CB_DIV   = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [IW-1:0]    r_a, n_a;
    logic [IW-1:0]    r_b, n_b;
    logic [IW-1:0]    r_acc, n_acc;
    logic [KW-1:0]    r_k, n_k;
    logic             r_valid, n_valid;
    logic [RES_W-1:0] r_result, n_result;
    logic [1:0]       r_status, n_status;

    ialu_pkg::t_mdu_req mdu_req;
    ialu_pkg::t_mdu_rsp mdu_rsp;
    logic [IW-1:0]      mdu_x;
    logic [IW-1:0]      mdu_y;
    logic [IW-1:0]      mdu_acc;
    logic [IW-1:0]      mdu_quo;

    logic          a_neg;
    logic          b_neg;
    logic [IW-1:0] mag_a;
    logic [IW-1:0] mag_b;
    logic          domain_bad;
    logic [IW-1:0] a_minus_k;
    logic [IW-1:0] k_plus;

    assign a_neg      = r_a[IW-1];
    assign b_neg      = r_b[IW-1];
    assign mag_a      = a_neg ? IW'(0) - r_a : r_a;
    assign mag_b      = b_neg ? IW'(0) - r_b : r_b;
    assign domain_bad = a_neg || b_neg || (r_b > r_a) || (r_a > IW'(MAX_FACT_N));
    assign a_minus_k  = r_a - IW'(r_k);
    assign k_plus     = IW'(r_k) + IW'(1);

    ialu_mdu #(
        .W(IW)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .i_x     (mdu_x),
        .i_y     (mdu_y),
        .o_rsp   (mdu_rsp),
        .o_acc   (mdu_acc),
        .o_quo   (mdu_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_k         = r_k;
        n_valid     = 1'b0;
        n_result    = r_result;
        n_status    = r_status;
        mdu_req.go  = 1'b0;
        mdu_req.div = 1'b0;
        mdu_x       = '0;
        mdu_y       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_a     = IW'($signed(i_operand_a));
                    n_b     = IW'($signed(i_operand_b));
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_op) inside
                    ialu_pkg::OP_ADD, ialu_pkg::OP_SUB: begin
                        n_result = (r_op == ialu_pkg::OP_ADD) ? RES_W'(r_a + r_b)
                                                              : RES_W'(r_a - r_b);
                        n_status = ialu_pkg::ST_OK;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end
                    ialu_pkg::OP_MUL: begin
                        mdu_req.go = 1'b1;
                        mdu_x      = r_a;
                        mdu_y      = r_b;
                        n_state    = S_WAIT;
                    end
                    ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
                        if (r_b == '0) begin
                            n_result = '0;
                            n_status = ialu_pkg::ST_DIV0;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            mdu_req.go  = 1'b1;
                            mdu_req.div = 1'b1;
                            mdu_x       = mag_a;
                            mdu_y       = mag_b;
                            n_state     = S_WAIT;
                        end
                    end
                    ialu_pkg::OP_POW: begin
                        if (b_neg) begin
                            n_result = RES_W'(1);
                            n_status = ialu_pkg::ST_OK;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_acc   = IW'(1);
                            n_state = S_PW_CHK;
                        end
                    end
                    default: begin
                        if (domain_bad) begin
                            n_result = '0;
                            n_status = ialu_pkg::ST_DOMAIN;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_acc   = IW'(1);
                            n_k     = '0;
                            n_state = S_CB_CHK;
                        end
                    end
                endcase
            end
            S_WAIT: begin
                if (mdu_rsp.done) begin
                    unique case (r_op) inside
                        ialu_pkg::OP_DIV: begin
                            n_result = (a_neg != b_neg) ? RES_W'(IW'(0) - mdu_quo)
                                                        : RES_W'(mdu_quo);
                        end
                        ialu_pkg::OP_REM: begin
                            n_result = a_neg ? RES_W'(IW'(0) - mdu_acc)
                                             : RES_W'(mdu_acc);
                        end
                        default: begin
                            n_result = RES_W'(mdu_acc);
                        end
                    endcase
                    n_status = ialu_pkg::ST_OK;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_PW_CHK: begin
                if (r_b == '0) begin
                    n_result = RES_W'(r_acc);
                    n_status = ialu_pkg::ST_OK;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_b[0]) begin
                    mdu_req.go = 1'b1;
                    mdu_x      = r_acc;
                    mdu_y      = r_a;
                    n_state    = S_PW_MUL;
                end else begin
                    mdu_req.go = 1'b1;
                    mdu_x      = r_a;
                    mdu_y      = r_a;
                    n_state    = S_PW_SQ;
                end
            end
            S_PW_MUL: begin
                if (mdu_rsp.done) begin
                    n_acc   = mdu_acc;
                    n_b     = {r_b[IW-1:1], 1'b0};
                    n_state = S_PW_CHK;
                end
            end
            S_PW_SQ: begin
                if (mdu_rsp.done) begin
                    n_a     = mdu_acc;
                    n_b     = r_b >> 1;
                    n_state = S_PW_CHK;
                end
            end
            S_CB_CHK: begin
                if (r_k == r_b[KW-1:0]) begin
                    n_result = RES_W'(r_acc);
                    n_status = ialu_pkg::ST_OK;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    mdu_req.go = 1'b1;
                    mdu_x      = r_acc;
                    mdu_y      = a_minus_k;
                    n_state    = S_CB_MUL;
                end
            end
            S_CB_MUL: begin
                if (mdu_rsp.done) begin
                    n_acc = mdu_acc;
                    if (r_op == ialu_pkg::OP_NCR) begin
                        n_state = S_CB_DIVGO;
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = S_CB_CHK;
                    end
                end
            end
            S_CB_DIVGO: begin
                mdu_req.go  = 1'b1;
                mdu_req.div = 1'b1;
                mdu_x       = r_acc;
                mdu_y       = k_plus;
                n_state     = S_CB_DIV;
            end
            S_CB_DIV: begin
                if (mdu_rsp.done) begin
                    n_acc   = mdu_quo;
                    n_k     = r_k + KW'(1);
                    n_state = S_CB_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_acc    <= n_acc;
        r_k      <= n_k;
        r_result <= n_result;
        r_status <= n_status;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_status = r_status;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ialu_pkg::ST_OK) || (o_result == '0))
        else $error("error status with nonzero result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_mdu_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_rsp.done || mdu_rsp.busy |-> busy)
        else $error("multiply/divide unit active while idle");

endmodule

// ===== rtl/ialu_mdu.sv =====
// ----------------------------------------------------------------------------
// ialu_mdu
// Iterative multiply / divide unit. Multiply takes one 8-bit digit of the
// multiplier per cycle (low W bits kept); divide is restoring, one bit/cycle.
// ----------------------------------------------------------------------------
module ialu_mdu #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ialu_pkg::t_mdu_req  i_req,
    input  logic [W-1:0]        i_x,
    input  logic [W-1:0]        i_y,
    output ialu_pkg::t_mdu_rsp  o_rsp,
    output logic [W-1:0]        o_acc,
    output logic [W-1:0]        o_quo
);

    localparam int MSTEPS = (W + ialu_pkg::DIGIT_W - 1) / ialu_pkg::DIGIT_W;
    localparam int CNT_W  = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_div;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_sh;
    logic [W-1:0]     r_op2;

    logic [W+ialu_pkg::DIGIT_W-1:0] pp;
    logic [W-1:0]                   sum;
    logic [W:0]                     rem_sh;
    logic [W:0]                     diff;
    logic [CNT_W-1:0]               last;

    assign pp     = r_sh * r_op2[ialu_pkg::DIGIT_W-1:0];
    assign sum    = r_acc + pp[W-1:0];
    assign rem_sh = {r_acc, r_sh[W-1]};
    assign diff   = rem_sh - {1'b0, r_op2};
    assign last   = r_div ? CNT_W'(W - 1) : CNT_W'(MSTEPS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_div <= i_req.div;
            r_cnt <= '0;
            r_acc <= '0;
            r_sh  <= i_x;
            r_op2 <= i_y;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_div) begin
                r_acc <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
                r_sh  <= {r_sh[W-2:0], ~diff[W]};
            end else begin
                r_acc <= sum;
                r_sh  <= r_sh << ialu_pkg::DIGIT_W;
                r_op2 <= r_op2 >> ialu_pkg::DIGIT_W;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_acc      = r_acc;
    assign o_quo      = r_sh;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer ALU: sends command items with random
// gaps, computes each answer independently, and checks every result strobe.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WIDTH     = 32;
    localparam int FACT_MAX  = 12;
    localparam int N_RANDOM  = 1225;

    typedef struct packed {
        logic [WIDTH-1:0] a;
        logic [2:0]       op;
        logic [WIDTH-1:0] b;
        logic [7:0]       gap;
    } t_alu_cmd;

    typedef struct packed {
        logic [WIDTH-1:0] a;
        logic [2:0]       op;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] value;
        logic [1:0]       status;
    } t_alu_answer;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [WIDTH-1:0] i_operand_a = '0;
    logic [2:0]       i_operation = ialu_pkg::OP_ADD;
    logic [WIDTH-1:0] i_operand_b = '0;
    logic             o_valid;
    logic [WIDTH-1:0] o_result;
    logic [1:0]       o_status;

    t_alu_cmd    commands_pending[$];
    t_alu_answer answers_due[$];
    t_alu_cmd    next_cmd;
    t_alu_answer want;
    int          gap_left = 0;
    int          n_total = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          n_status[3] = '{0, 0, 0};
    int          n_op[8] = '{0, 0, 0, 0, 0, 0, 0, 0};

    integer_alu_with_ncr_npr_top #(
        .DATA_WIDTH(WIDTH),
        .MAX_FACT_N(FACT_MAX)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operand_a(i_operand_a),
        .i_operation(i_operation),
        .i_operand_b(i_operand_b),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .o_status   (o_status)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10000000;
        $display("%0t: timeout, %0d of %0d items accepted, %0d results due",
                 $time, n_accepted, n_total, answers_due.size());
        $display("** integer_alu_with_ncr_npr_top: FAILED **");
        $finish;
    end

    function automatic t_alu_answer compute_alu(logic [WIDTH-1:0] a, logic [2:0] op,
                                                logic [WIDTH-1:0] b);
        t_alu_answer      ans;
        logic [WIDTH-1:0] ma;
        logic [WIDTH-1:0] mb;
        logic [WIDTH-1:0] acc;
        logic [WIDTH-1:0] base;
        longint unsigned  q;
        longint unsigned  f;
        int               i;
        ans.a      = a;
        ans.op     = op;
        ans.b      = b;
        ans.value  = '0;
        ans.status = ialu_pkg::ST_OK;
        ma = a[WIDTH-1] ? -a : a;
        mb = b[WIDTH-1] ? -b : b;
        case (op)
            ialu_pkg::OP_MUL: ans.value = a * b;
            ialu_pkg::OP_ADD: ans.value = a + b;
            ialu_pkg::OP_SUB: ans.value = a - b;
            ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
                if (b == '0) begin
                    ans.status = ialu_pkg::ST_DIV0;
                end else if (op == ialu_pkg::OP_DIV) begin
                    ans.value = ma / mb;
                    if (a[WIDTH-1] != b[WIDTH-1]) ans.value = -ans.value;
                end else begin
                    ans.value = ma % mb;
                    if (a[WIDTH-1]) ans.value = -ans.value;
                end
            end
            ialu_pkg::OP_POW: begin
                acc  = 1;
                base = a;
                if (!b[WIDTH-1]) begin
                    for (i = 0; i < WIDTH; i++) begin
                        if (b[i]) acc = acc * base;
                        base = base * base;
                    end
                end
                ans.value = acc;
            end
            default: begin
                if (a[WIDTH-1] || b[WIDTH-1] || b > a || a > FACT_MAX) begin
                    ans.status = ialu_pkg::ST_DOMAIN;
                end else begin
                    q = 1;
                    for (i = int'(a - b) + 1; i <= int'(a); i++) q = q * i;
                    if (op == ialu_pkg::OP_NCR) begin
                        f = 1;
                        for (i = 2; i <= int'(b); i++) f = f * i;
                        q = q / f;
                    end
                    ans.value = q[WIDTH-1:0];
                end
            end
        endcase
        return ans;
    endfunction

    function automatic logic [7:0] pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'd0;
        if (r < 85) return 8'($urandom_range(1, 4));
        if (r < 97) return 8'($urandom_range(5, 20));
        return 8'($urandom_range(30, 150));
    endfunction

    function automatic logic [WIDTH-1:0] rand_operand();
        logic [WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = WIDTH'($urandom_range(0, 32)) - WIDTH'(16);
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = 1;
                endcase
            end
            default: begin
                v = WIDTH'($urandom_range(0, 65535));
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic add_cmd(logic [WIDTH-1:0] a, logic [2:0] op, logic [WIDTH-1:0] b,
                           logic [7:0] gap);
        t_alu_cmd c;
        c.a   = a;
        c.op  = op;
        c.b   = b;
        c.gap = gap;
        commands_pending.push_back(c);
        n_total++;
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                answers_due.push_back(compute_alu(i_operand_a, i_operation, i_operand_b));
                n_op[i_operation]++;
                n_accepted++;
            end
            if (!(start && busy)) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end else if (commands_pending.size() != 0) begin
                    next_cmd = commands_pending.pop_front();
                    i_operand_a <= next_cmd.a;
                    i_operation <= next_cmd.op;
                    i_operand_b <= next_cmd.b;
                    start       <= 1'b1;
                    gap_left    <= next_cmd.gap;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result %h status %0d", $time, o_result, o_status);
                n_errors++;
            end else begin
                want = answers_due.pop_front();
                if (o_result !== want.value) begin
                    $display("%0t: op %0d a %h b %h: result expected %h actual %h",
                             $time, want.op, want.a, want.b, want.value, o_result);
                    n_errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: op %0d a %h b %h: status expected %0d actual %0d",
                             $time, want.op, want.a, want.b, want.status, o_status);
                    n_errors++;
                end
                if (want.status <= ialu_pkg::ST_DOMAIN) n_status[want.status]++;
                n_checked++;
            end
        end
    end

    initial begin
        logic [2:0]       op;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [7:0]       gap;
        int               n;

        // directed items
        add_cmd(32'h7fff_ffff, ialu_pkg::OP_MUL, 32'h7fff_ffff, pick_gap());
        add_cmd(32'h8000_0000, ialu_pkg::OP_MUL, 32'hffff_ffff, pick_gap());
        add_cmd(32'h7fff_ffff, ialu_pkg::OP_ADD, 32'h0000_0001, pick_gap());
        add_cmd(32'h8000_0000, ialu_pkg::OP_SUB, 32'h0000_0001, pick_gap());
        add_cmd(32'h8000_0000, ialu_pkg::OP_DIV, 32'hffff_ffff, pick_gap());
        add_cmd(32'h8000_0000, ialu_pkg::OP_REM, 32'hffff_ffff, pick_gap());
        add_cmd(32'hffff_fff9, ialu_pkg::OP_DIV, 32'h0000_0002, pick_gap());
        add_cmd(32'h0000_0007, ialu_pkg::OP_DIV, 32'hffff_fffe, pick_gap());
        add_cmd(32'hffff_fff9, ialu_pkg::OP_REM, 32'h0000_0002, pick_gap());
        add_cmd(32'h0000_0007, ialu_pkg::OP_REM, 32'hffff_fffe, pick_gap());
        add_cmd(32'h1234_5678, ialu_pkg::OP_DIV, 32'h0000_0000, pick_gap());
        add_cmd(32'h8000_0000, ialu_pkg::OP_REM, 32'h0000_0000, pick_gap());
        add_cmd(32'h0000_0005, ialu_pkg::OP_POW, 32'hffff_ffff, pick_gap());
        add_cmd(32'h0000_0000, ialu_pkg::OP_POW, 32'h0000_0000, pick_gap());
        add_cmd(32'h0000_0002, ialu_pkg::OP_POW, 32'h0000_001f, pick_gap());
        add_cmd(32'hffff_fffd, ialu_pkg::OP_POW, 32'h7fff_ffff, pick_gap());
        add_cmd(32'd12, ialu_pkg::OP_NCR, 32'd6, pick_gap());
        add_cmd(32'd12, ialu_pkg::OP_NCR, 32'd0, pick_gap());
        add_cmd(32'd0, ialu_pkg::OP_NCR, 32'd0, pick_gap());
        add_cmd(32'd12, ialu_pkg::OP_NPR, 32'd12, pick_gap());
        add_cmd(32'd5, ialu_pkg::OP_NCR, 32'd6, pick_gap());
        add_cmd(32'd13, ialu_pkg::OP_NPR, 32'd1, pick_gap());
        add_cmd(32'hffff_ffff, ialu_pkg::OP_NCR, 32'hffff_ffff, pick_gap());
        add_cmd(32'd4, ialu_pkg::OP_NPR, 32'hffff_ffff, pick_gap());

        // random items, with a burst of back-to-back items every 200
        for (int i = 0; i < N_RANDOM; i++) begin
            op  = 3'($urandom_range(0, 7));
            a   = rand_operand();
            b   = rand_operand();
            gap = ((i % 200) < 40) ? 8'd0 : pick_gap();
            case (op)
                ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
                    if ($urandom_range(0, 19) == 0) b = '0;
                end
                ialu_pkg::OP_POW: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: b = WIDTH'($urandom_range(0, 40));
                        6, 7:             b = 32'h8000_0000 | $urandom;
                        default:          b = $urandom;
                    endcase
                end
                ialu_pkg::OP_NCR, ialu_pkg::OP_NPR: begin
                    if ($urandom_range(0, 9) < 8) begin
                        n = $urandom_range(0, FACT_MAX);
                        a = WIDTH'(n);
                        b = WIDTH'($urandom_range(0, n));
                    end else if ($urandom_range(0, 1)) begin
                        a = WIDTH'($urandom_range(0, 15));
                        b = WIDTH'($urandom_range(0, 15));
                    end
                end
                default: ;
            endcase
            add_cmd(a, op, b, gap);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);

        $display("Checked %0d results: %0d ok, %0d divide-by-zero, %0d domain error",
                 n_checked, n_status[ialu_pkg::ST_OK], n_status[ialu_pkg::ST_DIV0],
                 n_status[ialu_pkg::ST_DOMAIN]);
        $display("Items per op mul/div/add/sub/rem/pow/ncr/npr: %0d %0d %0d %0d %0d %0d %0d %0d",
                 n_op[ialu_pkg::OP_MUL], n_op[ialu_pkg::OP_DIV],
                 n_op[ialu_pkg::OP_ADD], n_op[ialu_pkg::OP_SUB],
                 n_op[ialu_pkg::OP_REM], n_op[ialu_pkg::OP_POW],
                 n_op[ialu_pkg::OP_NCR], n_op[ialu_pkg::OP_NPR]);
        if (n_errors == 0) begin
            $display("** integer_alu_with_ncr_npr_top: PASSED **");
        end else begin
            $display("** integer_alu_with_ncr_npr_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ialu_pkg.sv
rtl/ialu_mdu.sv
rtl/integer_alu_with_ncr_npr_top.sv
tb/tb_top.sv
